// ===== src/coss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package coss_pkg;

   localparam int OFFSET_WIDTH   = 7;
   localparam int STRENGTH_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int REQ_DATA_WIDTH = 40;
   localparam int RSP_DATA_WIDTH = 24;

   // Largest magnitude a limit register may take when it is used.
   localparam logic signed [OFFSET_WIDTH-1:0] OFFSET_BOUND = 7'sd40;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FIRST_LIMIT    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LAST_LIMIT     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CENTRE_ONLY    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PICK_STRONGEST = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STRENGTH_FLOOR = 3'd4;

   localparam logic ACTION_START  = 1'b0;
   localparam logic ACTION_REPORT = 1'b1;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_CENTRE = 4'b0010,
      PH_DOWN   = 4'b0100,
      PH_UP     = 4'b1000
   } phase_type;

   typedef struct packed {
      logic                      action;
      logic                      probe_ok;
      logic                      strength_valid;
      logic [STRENGTH_WIDTH-1:0] strength;
   } item_type;

   // Limits arrive here already clamped to the legal offset range.
   typedef struct packed {
      logic [OFFSET_WIDTH-1:0]   first_limit;
      logic [OFFSET_WIDTH-1:0]   last_limit;
      logic                      centre_only;
      logic                      pick_strongest;
      logic [STRENGTH_WIDTH-1:0] strength_floor;
   } cfg_type;

   typedef struct packed {
      logic                    probe_request;
      logic [OFFSET_WIDTH-1:0] probe_offset;
      logic                    scan_done;
      logic                    signal_found;
      logic [OFFSET_WIDTH-1:0] chosen_offset;
   } result_type;

endpackage

`default_nettype wire

// ===== src/channel_offset_search_sequencer_unit.sv =====
//  channel | direction | handshake           | payload
//  req_    | in        | req_tvalid/tready   | req_tuser: action; req_tdata: probe result
//  rsp_    | out       | rsp_tvalid/tready   | rsp_tdata: next probe or scan outcome
//  csr_    | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
//  One request per cycle is sustained while rsp_tready stays high. While a request sits
//  in the input register the scan step works on it, and the edge that advances it updates
//  the scan state and loads the result register, which drives the response.
//  Reset is synchronous; it clears the scan state and restores register defaults.
//  A stalled response holds the result register; the input register still takes
//  one more request before req_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module channel_offset_search_sequencer_unit #(
   parameter int EXTEND_STEPS = 3
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // [0] probe_ok, [1] strength_valid, [33:2] strength, [39:34] zero
   input  wire logic [coss_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   // [0] action
   input  wire logic                                  req_tuser,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // [0] probe_request, [7:1] probe_offset, [8] scan_done, [9] signal_found,
   // [16:10] chosen_offset, [23:17] zero
   output logic [coss_pkg::RSP_DATA_WIDTH-1:0]        rsp_tdata,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [coss_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [coss_pkg::STRENGTH_WIDTH-1:0]   csr_wdata
);
   import coss_pkg::*;

   logic       in_valid_ff;
   item_type   in_item_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   logic       advance;
   cfg_type    cfg;
   result_type result;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.action         <= req_tuser;
         in_item_ff.probe_ok       <= req_tdata[0];
         in_item_ff.strength_valid <= req_tdata[1];
         in_item_ff.strength       <= req_tdata[STRENGTH_WIDTH+1:2];
      end
   end

   coss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   coss_scan #(
      .EXTEND_STEPS (EXTEND_STEPS)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_ff.chosen_offset, rsp_ff.signal_found, rsp_ff.scan_done,
                        rsp_ff.probe_offset, rsp_ff.probe_request};

endmodule

`default_nettype wire

// ===== src/coss_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module coss_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [coss_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [coss_pkg::STRENGTH_WIDTH-1:0]   csr_wdata,
   output coss_pkg::cfg_type                          cfg
);
   import coss_pkg::*;

   logic [OFFSET_WIDTH-1:0]   first_ff;
   logic [OFFSET_WIDTH-1:0]   last_ff;
   logic                      centre_ff;
   logic                      pick_ff;
   logic [STRENGTH_WIDTH-1:0] floor_ff;

   function automatic logic [OFFSET_WIDTH-1:0] clamp_offset(input logic [OFFSET_WIDTH-1:0] x);
      logic [OFFSET_WIDTH-1:0] y;
      y = x;
      if ($signed(x) < -OFFSET_BOUND) begin
         y = -OFFSET_BOUND;
      end else if ($signed(x) > OFFSET_BOUND) begin
         y = OFFSET_BOUND;
      end
      return y;
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= '0;
         last_ff   <= '0;
         centre_ff <= 1'b1;
         pick_ff   <= 1'b0;
         floor_ff  <= 32'd10;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FIRST_LIMIT:    first_ff  <= csr_wdata[OFFSET_WIDTH-1:0];
            CSR_LAST_LIMIT:     last_ff   <= csr_wdata[OFFSET_WIDTH-1:0];
            CSR_CENTRE_ONLY:    centre_ff <= csr_wdata[0];
            CSR_PICK_STRONGEST: pick_ff   <= csr_wdata[0];
            CSR_STRENGTH_FLOOR: floor_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.first_limit    = clamp_offset(first_ff);
      cfg.last_limit     = clamp_offset(last_ff);
      cfg.centre_only    = centre_ff;
      cfg.pick_strongest = pick_ff;
      cfg.strength_floor = floor_ff;
   end

endmodule

`default_nettype wire

// ===== src/coss_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none

module coss_scan #(
   parameter int EXTEND_STEPS = 3
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire coss_pkg::item_type item,
   input  wire coss_pkg::cfg_type  cfg,
   output coss_pkg::result_type result
);
   import coss_pkg::*;

   localparam logic signed [OFFSET_WIDTH:0] EXTEND = (OFFSET_WIDTH+1)'(EXTEND_STEPS);

   phase_type                        phase_ff, phase_in;
   logic signed [OFFSET_WIDTH-1:0]   cur_ff, cur_in;
   logic                             found_ff, found_in;
   logic signed [OFFSET_WIDTH-1:0]   low_ff, low_in;
   logic signed [OFFSET_WIDTH-1:0]   high_ff, high_in;
   logic signed [STRENGTH_WIDTH-1:0] best_ff, best_in;
   logic signed [OFFSET_WIDTH-1:0]   at_ff, at_in;

   logic signed [OFFSET_WIDTH-1:0]   first, last;
   logic signed [OFFSET_WIDTH-1:0]   down_off, up_off;
   logic                             down_ok, up_ok;
   logic                             start, weigh, below, good, better;
   logic signed [OFFSET_WIDTH:0]     next_dn, floor_dn, next_up, ceil_up;
   logic signed [OFFSET_WIDTH:0]     sum, sum_adj;
   logic signed [OFFSET_WIDTH-1:0]   chosen;
   logic                             req;
   phase_type                        req_phase;
   logic signed [OFFSET_WIDTH-1:0]   req_off;

   always_comb begin
      first = $signed(cfg.first_limit);
      last  = $signed(cfg.last_limit);
      start = (item.action == ACTION_START);

      // Strength only counts when the scan is not limited to the centre.
      weigh  = !cfg.centre_only && item.strength_valid;
      below  = $signed(item.strength) <= $signed(cfg.strength_floor);
      good   = item.probe_ok && !(weigh && below);
      better = item.probe_ok && weigh && !below && ($signed(item.strength) > best_ff);

      // Updated scan record; a start clears it and an idle report leaves it alone.
      cur_in   = cur_ff;
      found_in = found_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      best_in  = best_ff;
      at_in    = at_ff;
      if (start) begin
         cur_in   = '0;
         found_in = 1'b0;
         low_in   = '0;
         high_in  = '0;
         best_in  = '0;
         at_in    = '0;
      end else if (phase_ff != PH_IDLE) begin
         if (better) begin
            best_in = $signed(item.strength);
            at_in   = cur_ff;
         end
         if (good) begin
            if (!found_ff) begin
               found_in = 1'b1;
               low_in   = cur_ff;
               high_in  = cur_ff;
            end else if (cur_ff < low_ff) begin
               low_in = cur_ff;
            end else if (cur_ff > high_ff) begin
               high_in = cur_ff;
            end
         end
      end

      down_off = (last > 0) ? '0 : last;
      down_ok  = (first <= 0) && (down_off >= first);
      up_off   = (first <= 0) ? 7'sd1 : first;
      up_ok    = (last > 0) && (up_off <= last);

      next_dn  = {cur_ff[OFFSET_WIDTH-1], cur_ff} - 8'sd1;
      floor_dn = {first[OFFSET_WIDTH-1], first} - (good ? EXTEND : 8'sd0);
      next_up  = {cur_ff[OFFSET_WIDTH-1], cur_ff} + 8'sd1;
      ceil_up  = {last[OFFSET_WIDTH-1], last} + (good ? EXTEND : 8'sd0);

      // Midpoint of the good span, truncated toward zero.
      sum     = {low_in[OFFSET_WIDTH-1], low_in} + {high_in[OFFSET_WIDTH-1], high_in};
      sum_adj = sum + {{OFFSET_WIDTH{1'b0}}, sum[OFFSET_WIDTH]};
      chosen  = '0;
      if (found_in && !cfg.centre_only) begin
         if (cfg.pick_strongest && (best_in > 0)) begin
            chosen = at_in;
         end else begin
            chosen = sum_adj[OFFSET_WIDTH:1];
         end
      end

      req       = 1'b0;
      req_phase = PH_IDLE;
      req_off   = '0;
      if (start) begin
         req = 1'b1;
         if (cfg.centre_only) begin
            req_phase = PH_CENTRE;
         end else if (down_ok) begin
            req_phase = PH_DOWN;
            req_off   = down_off;
         end else if (up_ok) begin
            req_phase = PH_UP;
            req_off   = up_off;
         end else begin
            req = 1'b0;
         end
      end else begin
         unique case (phase_ff) inside
            PH_IDLE, PH_CENTRE: req = 1'b0;
            PH_DOWN: begin
               if (next_dn >= floor_dn) begin
                  req       = 1'b1;
                  req_phase = PH_DOWN;
                  req_off   = next_dn[OFFSET_WIDTH-1:0];
               end else if (up_ok) begin
                  req       = 1'b1;
                  req_phase = PH_UP;
                  req_off   = up_off;
               end
            end
            PH_UP: begin
               if (next_up <= ceil_up) begin
                  req       = 1'b1;
                  req_phase = PH_UP;
                  req_off   = next_up[OFFSET_WIDTH-1:0];
               end
            end
            default: req = 1'b0;
         endcase
      end

      phase_in = req_phase;
      if (req) begin
         cur_in = req_off;
      end

      result.probe_request = req;
      result.probe_offset  = req ? req_off : '0;
      result.scan_done     = !req;
      result.signal_found  = req ? 1'b0 : found_in;
      result.chosen_offset = req ? '0 : chosen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cur_ff   <= '0;
         found_ff <= 1'b0;
         low_ff   <= '0;
         high_ff  <= '0;
         best_ff  <= '0;
         at_ff    <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         cur_ff   <= cur_in;
         found_ff <= found_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
         best_ff  <= best_in;
         at_ff    <= at_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/coss_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module coss_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 rsp_tvalid,
   input wire logic                                 rsp_tready,
   input wire logic [coss_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata
);

   // Every response either asks for a probe or closes the scan, never both.
   a_request_xor_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] ^ rsp_tdata[8]))
      else $error("response is neither a probe request nor a finished scan");

   // While probing, the outcome fields stay clear.
   a_probe_clears_outcome: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> (rsp_tdata[16:9] == 8'd0))
      else $error("probe request carries an outcome");

   // A finished scan carries no probe offset.
   a_done_clears_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[7:1] == 7'd0))
      else $error("finished scan carries a probe offset");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind channel_offset_search_sequencer_unit coss_checker u_coss_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
